>>> rtl/core/mse_pkg.sv
// ----------------------------------------------------------------------------
// Multi-set bitmap engine package
// Sizes, field types, operation codes and the structs that pass between the
// controller, the word unit and the set memory.
// ----------------------------------------------------------------------------
package mse_pkg;

    // Geometry of the set storage.
    localparam int NUM_SETS  = 8;
    localparam int MAX_IDS   = 1024;
    localparam int WORD_BITS = 32;
    localparam int WPS       = (MAX_IDS + WORD_BITS - 1) / WORD_BITS;
    localparam int DEPTH     = NUM_SETS * WPS;

    // Field widths of the request and result.
    localparam int OP_W  = 4;
    localparam int SET_W = 3;
    localparam int ID_W  = 10;
    localparam int CNT_W = 10;

    // Derived widths.
    localparam int BIT_W   = $clog2(WORD_BITS);
    localparam int WIDX_W  = $clog2(WPS);
    localparam int SETA_W  = $clog2(NUM_SETS);
    localparam int ADDR_W  = SETA_W + WIDX_W;
    localparam int ACC_W   = $clog2(MAX_IDS + 1);
    localparam int PCNT_W  = $clog2(WORD_BITS + 1);
    localparam int CNT_MAX = (1 << CNT_W) - 1;

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_INSERT  = 4'd0,
        OP_REMOVE  = 4'd1,
        OP_TEST    = 4'd2,
        OP_CLEAR   = 4'd3,
        OP_LOWEST  = 4'd4,
        OP_EXTRACT = 4'd5,
        OP_COUNT   = 4'd6,
        OP_UNION   = 4'd7,
        OP_DIFF    = 4'd8,
        OP_INTER   = 4'd9,
        OP_NEXT    = 4'd10
    } op_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_STREAM,
        ST_RESP
    } state_t;

    // Request transfer payload.
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [SET_W-1:0] set_a;
        logic [SET_W-1:0] set_b;
        logic [ID_W-1:0]  element;
    } req_t;

    // Result transfer payload.
    typedef struct packed {
        logic             hit;
        logic [ID_W-1:0]  member_id;
        logic [CNT_W-1:0] member_count;
        logic             bad_id;
    } rsp_t;

    // Controls from the controller to the word unit.
    typedef struct packed {
        op_t              op;
        logic             first;
        logic [BIT_W-1:0] offset;
        logic [BIT_W-1:0] bit_sel;
    } wu_ctl_t;

    // Results of the word unit for the word on the memory output.
    typedef struct packed {
        logic [WORD_BITS-1:0] merged;
        logic                 found;
        logic [BIT_W-1:0]     low_idx;
        logic [PCNT_W-1:0]    pcnt;
        logic                 bit_hit;
    } wu_res_t;

    // Memory port commands from the controller.
    typedef struct packed {
        logic                 we;
        logic [ADDR_W-1:0]    waddr;
        logic [WORD_BITS-1:0] wdata;
        logic [ADDR_W-1:0]    raddr_a;
        logic [ADDR_W-1:0]    raddr_b;
    } ram_cmd_t;

endpackage

>>> rtl/core/mse_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // Write port and registered reads.
    always_ff @(posedge clk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
        rdata_a_reg <= mem_array[raddr_a];
        rdata_b_reg <= mem_array[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

>>> rtl/core/mse_word_unit.sv
// ----------------------------------------------------------------------------
// Multi-set bitmap word unit
// Works on one word from each read port: lowest set bit at or above a start
// offset, population count, single-bit test and the read-modify-write value.
// ----------------------------------------------------------------------------
module mse_word_unit import mse_pkg::*; (
    input  logic [WORD_BITS-1:0] word_a,
    input  logic [WORD_BITS-1:0] word_b,
    input  wu_ctl_t              ctl,
    output wu_res_t              res
);

    localparam int NBYTES = WORD_BITS / 8;
    localparam logic [WORD_BITS-1:0] ONES = '1;
    localparam logic [WORD_BITS-1:0] M1   = {(WORD_BITS / 2){2'b01}};
    localparam logic [WORD_BITS-1:0] M2   = {(WORD_BITS / 4){4'b0011}};
    localparam logic [WORD_BITS-1:0] M4   = {(WORD_BITS / 8){8'h0F}};

    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] masked;
    logic [WORD_BITS-1:0] lowbit;
    logic [WORD_BITS-1:0] onehot;
    logic [WORD_BITS-1:0] v1;
    logic [WORD_BITS-1:0] v2;
    logic [WORD_BITS-1:0] v4;
    logic [BIT_W-1:0]     low_idx;
    logic [PCNT_W-1:0]    pcnt;

    // Lowest member at or above the start offset in the first word.
    always_comb begin
        mask    = ctl.first ? (ONES << ctl.offset) : ONES;
        masked  = word_a & mask;
        lowbit  = masked & (~masked + WORD_BITS'(1));
        low_idx = '0;
        for (int k = 0; k < WORD_BITS; k++) begin
            if (lowbit[k]) begin
                low_idx = low_idx | BIT_W'(k);
            end
        end
    end

    // Population count: pair, nibble and byte sums, then a short byte adder.
    always_comb begin
        v1   = word_a - ((word_a >> 1) & M1);
        v2   = (v1 & M2) + ((v1 >> 2) & M2);
        v4   = (v2 + (v2 >> 4)) & M4;
        pcnt = '0;
        for (int j = 0; j < NBYTES; j++) begin
            pcnt = pcnt + PCNT_W'(v4[j*8 +: 8]);
        end
    end

    assign onehot = WORD_BITS'(1) << ctl.bit_sel;

    // Value written back for each operation.
    always_comb begin
        res.found   = masked != '0;
        res.low_idx = low_idx;
        res.pcnt    = pcnt;
        res.bit_hit = (word_a & onehot) != '0;
        case (ctl.op)
            OP_INSERT:  res.merged = word_a | onehot;
            OP_REMOVE:  res.merged = word_a & ~onehot;
            OP_CLEAR:   res.merged = '0;
            OP_EXTRACT: res.merged = word_a & ~lowbit;
            OP_UNION:   res.merged = word_a | word_b;
            OP_DIFF:    res.merged = word_a & ~word_b;
            OP_INTER:   res.merged = word_a & word_b;
            default:    res.merged = word_a;
        endcase
    end

endmodule

>>> rtl/core/mse_ctrl.sv
// ----------------------------------------------------------------------------
// Multi-set bitmap controller
// Takes requests, walks the words of a set through the memory, writes
// modified words back and registers the result transfer.
// ----------------------------------------------------------------------------
module mse_ctrl import mse_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  req_t     s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output rsp_t     m_data,
    output ram_cmd_t ram_cmd,
    output wu_ctl_t  wu_ctl,
    input  wu_res_t  wu_res
);

    localparam logic [WIDX_W-1:0] LAST_WIDX = WIDX_W'(WPS - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    state_t             state_reg, state_next;
    req_t               req_reg, req_next;
    logic [WIDX_W-1:0]  start_idx_reg, start_idx_next;
    logic [WIDX_W-1:0]  end_idx_reg, end_idx_next;
    logic [BIT_W-1:0]   off_reg, off_next;
    logic [WIDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic               rd_act_reg, rd_act_next;
    logic               pend_reg, pend_next;
    logic [WIDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    rsp_t               rsp_reg, rsp_next;
    logic               m_valid_reg, m_valid_next;
    rsp_t               m_data_reg, m_data_next;
    logic [ADDR_W-1:0]  init_cnt_reg, init_cnt_next;

    // Request decode signals.
    op_t                in_op;
    logic               in_el_ok;
    logic               in_sets_ok;
    logic [ID_W:0]      nstart;
    logic               nstart_ok;
    logic [WIDX_W-1:0]  el_widx;
    logic [WIDX_W-1:0]  nstart_widx;
    logic               go;
    op_t                cur_op;
    logic               last;
    logic               out_free;

    assign in_op       = op_t'(s_data.op);
    assign in_el_ok    = (s_data.element != '0) && (32'(s_data.element) < MAX_IDS);
    assign in_sets_ok  = (32'(s_data.set_a) < NUM_SETS) &&
                         (!(in_op == OP_UNION || in_op == OP_DIFF || in_op == OP_INTER) ||
                          (32'(s_data.set_b) < NUM_SETS));
    assign nstart      = {1'b0, s_data.element} + (ID_W + 1)'(1);
    assign nstart_ok   = 32'(nstart) < MAX_IDS;
    assign el_widx     = WIDX_W'(s_data.element >> BIT_W);
    assign nstart_widx = WIDX_W'(nstart >> BIT_W);

    assign cur_op   = op_t'(req_reg.op);
    assign last     = pend_idx_reg == end_idx_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Word unit controls for the word now on the memory output.
    assign wu_ctl.op      = cur_op;
    assign wu_ctl.first   = pend_idx_reg == start_idx_reg;
    assign wu_ctl.offset  = off_reg;
    assign wu_ctl.bit_sel = req_reg.element[BIT_W-1:0];

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            rd_act_reg   <= 1'b0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            init_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            rd_act_reg   <= rd_act_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
            init_cnt_reg <= init_cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        start_idx_reg <= start_idx_next;
        end_idx_reg   <= end_idx_next;
        off_reg       <= off_next;
        rd_idx_reg    <= rd_idx_next;
        pend_idx_reg  <= pend_idx_next;
        acc_reg       <= acc_next;
        rsp_reg       <= rsp_next;
        m_data_reg    <= m_data_next;
    end

    // Next state, memory commands and results.
    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        start_idx_next = start_idx_reg;
        end_idx_next   = end_idx_reg;
        off_next       = off_reg;
        rd_idx_next    = rd_idx_reg;
        rd_act_next    = rd_act_reg;
        pend_next      = (state_reg == ST_STREAM) && rd_act_reg;
        pend_idx_next  = rd_idx_reg;
        acc_next       = acc_reg;
        rsp_next       = rsp_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        init_cnt_next  = init_cnt_reg;
        go             = 1'b0;

        ram_cmd.we      = 1'b0;
        ram_cmd.waddr   = {SETA_W'(req_reg.set_a), pend_idx_reg};
        ram_cmd.wdata   = wu_res.merged;
        ram_cmd.raddr_a = {SETA_W'(req_reg.set_a), rd_idx_reg};
        ram_cmd.raddr_b = {SETA_W'(req_reg.set_b), rd_idx_reg};

        case (state_reg)
            // Zero every word of the memory after reset.
            ST_INIT: begin
                ram_cmd.we    = 1'b1;
                ram_cmd.waddr = init_cnt_reg;
                ram_cmd.wdata = '0;
                init_cnt_next = init_cnt_reg + ADDR_W'(1);
                if (init_cnt_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end

            // Accept a request and set up the word range to walk.
            ST_IDLE: begin
                if (s_valid) begin
                    req_next       = s_data;
                    rsp_next       = '0;
                    acc_next       = '0;
                    pend_next      = 1'b0;
                    start_idx_next = '0;
                    end_idx_next   = LAST_WIDX;
                    off_next       = '0;
                    if (in_sets_ok) begin
                        case (in_op)
                            OP_INSERT: begin
                                if (s_data.element == '0) begin
                                    rsp_next.bad_id = 1'b1;
                                end else if (in_el_ok) begin
                                    go             = 1'b1;
                                    start_idx_next = el_widx;
                                    end_idx_next   = el_widx;
                                end
                            end
                            OP_REMOVE, OP_TEST: begin
                                if (in_el_ok) begin
                                    go             = 1'b1;
                                    start_idx_next = el_widx;
                                    end_idx_next   = el_widx;
                                end
                            end
                            OP_CLEAR, OP_COUNT, OP_UNION, OP_DIFF, OP_INTER: begin
                                go = 1'b1;
                            end
                            OP_LOWEST, OP_EXTRACT: begin
                                go       = 1'b1;
                                off_next = BIT_W'(1);
                            end
                            OP_NEXT: begin
                                if (nstart_ok) begin
                                    go             = 1'b1;
                                    start_idx_next = nstart_widx;
                                    off_next       = nstart[BIT_W-1:0];
                                end
                            end
                            default: begin
                                go = 1'b0;
                            end
                        endcase
                    end
                    rd_idx_next = start_idx_next;
                    rd_act_next = go;
                    state_next  = go ? ST_STREAM : ST_RESP;
                end
            end

            // Issue one read per cycle and process the word read last cycle.
            ST_STREAM: begin
                if (rd_act_reg) begin
                    rd_idx_next = rd_idx_reg + WIDX_W'(1);
                    if (rd_idx_reg == end_idx_reg) begin
                        rd_act_next = 1'b0;
                    end
                end
                if (pend_reg) begin
                    case (cur_op)
                        OP_INSERT, OP_REMOVE: begin
                            ram_cmd.we = 1'b1;
                            state_next = ST_RESP;
                        end
                        OP_TEST: begin
                            rsp_next.hit = wu_res.bit_hit;
                            state_next   = ST_RESP;
                        end
                        OP_CLEAR, OP_UNION, OP_DIFF, OP_INTER: begin
                            ram_cmd.we = 1'b1;
                            if (last) begin
                                state_next = ST_RESP;
                            end
                        end
                        OP_LOWEST, OP_EXTRACT, OP_NEXT: begin
                            if (wu_res.found) begin
                                rsp_next.hit       = 1'b1;
                                rsp_next.member_id = ID_W'({pend_idx_reg, wu_res.low_idx});
                                ram_cmd.we         = cur_op == OP_EXTRACT;
                                state_next         = ST_RESP;
                            end else if (last) begin
                                state_next = ST_RESP;
                            end
                        end
                        OP_COUNT: begin
                            acc_next = acc_reg + ACC_W'(wu_res.pcnt);
                            if (last) begin
                                rsp_next.hit          = acc_next != '0;
                                rsp_next.member_count = (32'(acc_next) > CNT_MAX) ?
                                                        CNT_W'(CNT_MAX) : CNT_W'(acc_next);
                                state_next            = ST_RESP;
                            end
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            // Hand the result to the output register once it is free.
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = rsp_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The memory is never written between requests.
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !ram_cmd.we)
        else $error("memory written while idle");

    // No request is taken during the clearing sweep.
    a_init_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_INIT |-> !s_ready)
        else $error("request taken during memory clear");

    // A request only ever modifies words of its own set.
    a_write_own_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STREAM && ram_cmd.we) |->
        ram_cmd.waddr[ADDR_W-1:WIDX_W] == SETA_W'(req_reg.set_a))
        else $error("write outside the addressed set");

    // A found member always comes with a hit.
    a_id_has_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.member_id != '0) |-> m_data_reg.hit)
        else $error("member id without hit");

    // A finished result reaches the output register in the next cycle.
    a_resp_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESP && out_free) |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("result not loaded into output register");

endmodule

>>> rtl/core/multi_set_bitmap_engine_top.sv
// ----------------------------------------------------------------------------
// Multi-set bitmap engine
// Keeps eight sets of element IDs as bitmaps in one word memory and serves
// insert, remove, test, clear, lowest, extract, count, union, difference,
// intersection and next-member requests.
//
//   Channel  Ports               Direction  Content
//   request  s_valid/s_ready     in         s_data: op, set_a, set_b, element
//   result   m_valid/m_ready     out        m_data: hit, member_id,
//                                           member_count, bad_id
//
// Insert, remove and test touch a single word; whole-set requests walk
// every word of the set, one memory read per word.
// Lowest, extract and next stop at the first word that holds a member.
// After reset every word of the memory is cleared with s_ready low.
// A result waits in the output register while m_ready is low; the next
// request is still taken and held until the output register frees up.
// ----------------------------------------------------------------------------
module multi_set_bitmap_engine_top import mse_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    ram_cmd_t             ram_cmd;
    wu_ctl_t              wu_ctl;
    wu_res_t              wu_res;
    logic [WORD_BITS-1:0] rdata_a;
    logic [WORD_BITS-1:0] rdata_b;

    // Request sequencing and result register.
    mse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .ram_cmd (ram_cmd),
        .wu_ctl  (wu_ctl),
        .wu_res  (wu_res)
    );

    // Set word storage.
    mse_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (aclk),
        .we      (ram_cmd.we),
        .waddr   (ram_cmd.waddr),
        .wdata   (ram_cmd.wdata),
        .raddr_a (ram_cmd.raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (ram_cmd.raddr_b),
        .rdata_b (rdata_b)
    );

    // Per-word search, count and modify logic.
    mse_word_unit u_word_unit (
        .word_a (rdata_a),
        .word_b (rdata_b),
        .ctl    (wu_ctl),
        .res    (wu_res)
    );

endmodule
